/* src/nfcp_pkg.sv */
// Shared constants, codes and stage types for the NOR flash command planner.
package nfcp_pkg;

    // Address handling
    localparam int ADDR_BITS = 32;
    localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);

    // Erase granularity checked on the first step of an erase
    localparam int SECTOR_LOG2 = 12;
    localparam logic [31:0] SECTOR_MASK = 32'((64'd1 << SECTOR_LOG2) - 64'd1);

    // Erase type slots held in registers
    localparam int TYPE_SLOTS = 4;
    localparam int NUM_ERASE_TYPES = 4;

    // Register indexes
    localparam logic [2:0] REG_FLASH_BYTES = 3'd0;
    localparam logic [2:0] REG_PAGE_LOG2   = 3'd1;
    localparam logic [2:0] REG_ERASE_A     = 3'd2;

    // Register reset values
    localparam logic [31:0] FLASH_BYTES_RST = 32'd16777216;
    localparam logic [3:0]  PAGE_LOG2_RST   = 4'd8;
    localparam logic [12:0] ERASE_A_RST     = 13'd3104;
    localparam logic [12:0] ERASE_B_RST     = 13'd3928;

    // Request kinds
    localparam logic [1:0] CMD_READ    = 2'd0;
    localparam logic [1:0] CMD_PROGRAM = 2'd1;
    localparam logic [1:0] CMD_ERASE   = 2'd2;
    localparam logic [1:0] CMD_BAD     = 2'd3;

    // Result status
    localparam logic [2:0] ST_CHUNK     = 3'd0;
    localparam logic [2:0] ST_NOTHING   = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_MISALIGN  = 3'd3;
    localparam logic [2:0] ST_NO_TYPE   = 3'd4;

    // Operation kinds
    localparam logic [2:0] OP_NONE       = 3'd0;
    localparam logic [2:0] OP_READ       = 3'd1;
    localparam logic [2:0] OP_PROGRAM    = 3'd2;
    localparam logic [2:0] OP_CHIP_ERASE = 3'd3;
    localparam logic [2:0] OP_BLK_ERASE  = 3'd4;

    function automatic logic [12:0] erase_rst(input int slot);
        logic [12:0] v;
        v = 13'd0;
        if (slot == 0) v = ERASE_A_RST;
        if (slot == 1) v = ERASE_B_RST;
        return v;
    endfunction

    // Output of the check stage
    typedef struct packed {
        logic                  valid;
        logic [1:0]            cmd;
        logic                  first;
        logic [31:0]           addr;
        logic [31:0]           rem;
        logic                  addr_ge;
        logic [31:0]           room;
        logic                  rem_zero;
        logic                  sector_ok;
        logic                  chip_match;
        logic [15:0]           page_len;
        logic [TYPE_SLOTS-1:0] type_fit;
    } check_t;

    // Output of the select stage
    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic [2:0]  op_kind;
        logic [7:0]  opcode;
        logic [31:0] addr;
        logic [31:0] len;
        logic [31:0] rem;
        logic        last;
    } select_t;

endpackage

/* src/nfcp_check.sv */
// Stage 1: range arithmetic, page offset and per-type alignment flags.
module nfcp_check #(
    parameter int NUM_TYPES = nfcp_pkg::NUM_ERASE_TYPES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          cmd,
    input  logic [31:0]         addr,
    input  logic [31:0]         remaining_in,
    input  logic                first,
    input  logic [31:0]         flash_bytes,
    input  logic [3:0]          page_log2,
    input  logic [12:0]         type_cfg [NUM_TYPES],
    output nfcp_pkg::check_t    stage
);

    logic              valid_reg;
    nfcp_pkg::check_t  data_reg;
    nfcp_pkg::check_t  data_next;

    logic [31:0] addr_m;
    logic [32:0] diff;
    logic [15:0] page;
    logic [15:0] page_off;
    logic [4:0]  e;
    logic [31:0] m;

    always_comb
    begin
        addr_m = addr & nfcp_pkg::ADDR_MASK;
        diff   = {1'b0, flash_bytes} - {1'b0, addr_m};
        page   = 16'd1 << page_log2;
        page_off = addr_m[15:0] & (page - 16'd1);

        data_next            = '0;
        data_next.valid      = start;
        data_next.cmd        = cmd;
        data_next.first      = first;
        data_next.addr       = addr_m;
        data_next.rem        = remaining_in;
        // borrow or zero room: address at or past the end
        data_next.addr_ge    = diff[32] || (diff[31:0] == 32'd0);
        data_next.room       = diff[31:0];
        data_next.rem_zero   = (remaining_in == 32'd0);
        data_next.sector_ok  = ((addr_m & nfcp_pkg::SECTOR_MASK) == 32'd0) &&
                               ((remaining_in & nfcp_pkg::SECTOR_MASK) == 32'd0);
        data_next.chip_match = (addr_m == 32'd0) && (remaining_in == flash_bytes);
        data_next.page_len   = page - page_off;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            e = type_cfg[i][12:8];
            m = ~(32'hFFFF_FFFF << e);
            data_next.type_fit[i] = (e != 5'd0) && ((addr_m & m) == 32'd0) &&
                                    ((remaining_in & m) == 32'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        stage       = data_reg;
        stage.valid = valid_reg;
    end

endmodule

/* src/nfcp_select.sv */
// Stage 2: range decision, case selection and erase type choice.
module nfcp_select #(
    parameter int NUM_TYPES = nfcp_pkg::NUM_ERASE_TYPES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  nfcp_pkg::check_t   chk,
    input  logic [12:0]        type_cfg [NUM_TYPES],
    output nfcp_pkg::select_t  stage
);

    logic               valid_reg;
    nfcp_pkg::select_t  data_reg;
    nfcp_pkg::select_t  data_next;

    logic        range_fail;
    logic        page_fits;
    logic        found;
    logic [4:0]  best_exp;
    logic [7:0]  best_opc;
    logic [31:0] blk_len;

    always_comb
    begin
        // largest aligned type; ties go to the lower slot
        found    = 1'b0;
        best_exp = 5'd0;
        best_opc = 8'd0;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            if (chk.type_fit[i] && (!found || (type_cfg[i][12:8] > best_exp)))
            begin
                found    = 1'b1;
                best_exp = type_cfg[i][12:8];
                best_opc = type_cfg[i][7:0];
            end
        end
        blk_len = 32'd1 << best_exp;

        range_fail = (chk.cmd == nfcp_pkg::CMD_BAD) ||
                     (chk.first && (chk.addr_ge || (chk.room < chk.rem)));
        page_fits  = ({16'd0, chk.page_len} >= chk.rem);

        data_next         = '0;
        data_next.valid   = chk.valid;
        data_next.addr    = chk.addr;
        data_next.rem     = chk.rem;
        data_next.status  = nfcp_pkg::ST_CHUNK;
        data_next.op_kind = nfcp_pkg::OP_NONE;
        data_next.last    = 1'b1;

        if (range_fail)
            data_next.status = nfcp_pkg::ST_RANGE;
        else if (chk.rem_zero)
            data_next.status = nfcp_pkg::ST_NOTHING;
        else
        begin
            case (chk.cmd)
                nfcp_pkg::CMD_READ:
                begin
                    data_next.op_kind = nfcp_pkg::OP_READ;
                    data_next.len     = chk.rem;
                end
                nfcp_pkg::CMD_PROGRAM:
                begin
                    data_next.op_kind = nfcp_pkg::OP_PROGRAM;
                    data_next.len     = page_fits ? chk.rem : {16'd0, chk.page_len};
                    data_next.last    = page_fits;
                end
                default:
                begin
                    if (chk.first && !chk.sector_ok)
                        data_next.status = nfcp_pkg::ST_MISALIGN;
                    else if (chk.chip_match)
                    begin
                        data_next.op_kind = nfcp_pkg::OP_CHIP_ERASE;
                        data_next.len     = chk.rem;
                    end
                    else if (found)
                    begin
                        data_next.op_kind = nfcp_pkg::OP_BLK_ERASE;
                        data_next.opcode  = best_opc;
                        data_next.len     = blk_len;
                        data_next.last    = (chk.rem == blk_len);
                    end
                    else
                        data_next.status = nfcp_pkg::ST_NO_TYPE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= chk.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        stage       = data_reg;
        stage.valid = valid_reg;
    end

endmodule

/* src/nfcp_finish.sv */
// Stage 3: next address and remaining count, registered result ports.
module nfcp_finish (
    input  logic               clk,
    input  logic               rst_n,
    input  nfcp_pkg::select_t  sel,
    output logic               done,
    output logic [2:0]         status,
    output logic [2:0]         op_kind,
    output logic [7:0]         erase_opcode,
    output logic [31:0]        chunk_addr,
    output logic [31:0]        chunk_len,
    output logic [31:0]        next_addr,
    output logic [31:0]        remaining_out,
    output logic               last
);

    logic        done_reg;
    logic [2:0]  status_reg;
    logic [2:0]  op_kind_reg;
    logic [7:0]  opcode_reg;
    logic [31:0] chunk_addr_reg;
    logic [31:0] chunk_len_reg;
    logic [31:0] next_addr_reg;
    logic [31:0] next_addr_next;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic        last_reg;

    // failures carry len 0, so these give addr and rem back unchanged
    assign next_addr_next = (sel.addr + sel.len) & nfcp_pkg::ADDR_MASK;
    assign rem_next       = sel.rem - sel.len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sel.valid;
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= sel.status;
        op_kind_reg    <= sel.op_kind;
        opcode_reg     <= sel.opcode;
        chunk_addr_reg <= sel.addr;
        chunk_len_reg  <= sel.len;
        next_addr_reg  <= next_addr_next;
        rem_reg        <= rem_next;
        last_reg       <= sel.last;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign op_kind       = op_kind_reg;
    assign erase_opcode  = opcode_reg;
    assign chunk_addr    = chunk_addr_reg;
    assign chunk_len     = chunk_len_reg;
    assign next_addr     = next_addr_reg;
    assign remaining_out = rem_reg;
    assign last          = last_reg;

endmodule

/* src/nor_flash_command_planner.sv */
// Top level of the NOR flash command planner: config registers and three-stage pipeline.
//
// Plans one SPI NOR command chunk per step: a pulse on start (busy is always low, so
// every start is taken) transfers cmd/addr/remaining_in/first in; once the step has
// passed the check, select and finish register stages, done is high for one cycle
// with the chunk (status, op_kind, erase_opcode, chunk_addr, chunk_len, next_addr,
// remaining_out, last). A new step can be started on every clock; throughput is one
// step per cycle. The receiver cannot stall done, so results must be captured in the
// cycle they appear. Feed next_addr and remaining_out back as addr and remaining_in
// with first low until last is set. Configuration registers may only be written
// while no step is in flight.
module nor_flash_command_planner #(
    parameter int NUM_ERASE_TYPES = nfcp_pkg::NUM_ERASE_TYPES
) (
    input  logic        clk,
    input  logic        rst_n,

    // step transfer
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [31:0] addr,
    input  logic [31:0] remaining_in,
    input  logic        first,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,

    // result transfer
    output logic        done,
    output logic [2:0]  status,
    output logic [2:0]  op_kind,
    output logic [7:0]  erase_opcode,
    output logic [31:0] chunk_addr,
    output logic [31:0] chunk_len,
    output logic [31:0] next_addr,
    output logic [31:0] remaining_out,
    output logic        last
);

    // only the first four types exist in registers; more are treated as absent
    localparam int NUM_SLOTS = (NUM_ERASE_TYPES < nfcp_pkg::TYPE_SLOTS) ?
                               NUM_ERASE_TYPES : nfcp_pkg::TYPE_SLOTS;

    logic [31:0] flash_bytes_reg;
    logic [3:0]  page_log2_reg;
    logic [12:0] erase_type_reg [NUM_SLOTS];

    nfcp_pkg::check_t  chk;
    nfcp_pkg::select_t sel;

    // pipeline never holds off a step
    assign busy = 1'b0;

    // Config registers. Each erase type packs a 5-bit size exponent over an opcode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_bytes_reg <= nfcp_pkg::FLASH_BYTES_RST;
            page_log2_reg   <= nfcp_pkg::PAGE_LOG2_RST;
            for (int i = 0; i < NUM_SLOTS; i++)
                erase_type_reg[i] <= nfcp_pkg::erase_rst(i);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                nfcp_pkg::REG_FLASH_BYTES: flash_bytes_reg <= cfg_wdata;
                nfcp_pkg::REG_PAGE_LOG2:   page_log2_reg   <= cfg_wdata[3:0];
                default: ;
            endcase
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (cfg_index == 3'(nfcp_pkg::REG_ERASE_A + 3'(i)))
                    erase_type_reg[i] <= cfg_wdata[12:0];
            end
        end
    end

    // Stage 1: flash room, page remainder, alignment per erase type
    nfcp_check #(
        .NUM_TYPES (NUM_SLOTS)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .addr         (addr),
        .remaining_in (remaining_in),
        .first        (first),
        .flash_bytes  (flash_bytes_reg),
        .page_log2    (page_log2_reg),
        .type_cfg     (erase_type_reg),
        .stage        (chk)
    );

    // Stage 2: status, operation and chunk length
    nfcp_select #(
        .NUM_TYPES (NUM_SLOTS)
    ) u_select (
        .clk         (clk),
        .rst_n       (rst_n),
        .chk         (chk),
        .type_cfg    (erase_type_reg),
        .stage       (sel)
    );

    // Stage 3: next address / remaining count into the result registers
    nfcp_finish u_finish (
        .clk           (clk),
        .rst_n         (rst_n),
        .sel           (sel),
        .done          (done),
        .status        (status),
        .op_kind       (op_kind),
        .erase_opcode  (erase_opcode),
        .chunk_addr    (chunk_addr),
        .chunk_len     (chunk_len),
        .next_addr     (next_addr),
        .remaining_out (remaining_out),
        .last          (last)
    );

endmodule
